[design/vsa_pkg.sv]
package vsa_pkg;

	localparam int HOSTS_W  = 16;
	localparam int NUM_W    = 6;
	localparam int ADDR_W   = 8;
	localparam int SIZE_W   = 9;
	localparam int PFX_W    = 5;
	localparam int ENTRY_W  = NUM_W + HOSTS_W;
	localparam int Q_DEPTH  = 4;
	localparam int Q_CNT_W  = 3;
	localparam int SPACE    = 256;
	localparam int MAX_BITS = 8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;

	typedef struct packed {
		logic [HOSTS_W-1:0] required_hosts;
		logic               last_request;
	} in_t;

	typedef struct packed {
		logic [NUM_W-1:0]   subnet_number;
		logic [1:0]         status;
		logic [HOSTS_W-1:0] hosts_echo;
		logic [ADDR_W-1:0]  network_addr;
		logic [ADDR_W-1:0]  first_host_addr;
		logic [ADDR_W-1:0]  last_host_addr;
		logic [ADDR_W-1:0]  broadcast_addr;
		logic [PFX_W-1:0]   prefix_len;
		logic [SIZE_W-1:0]  block_size;
		logic               last_result;
	} out_t;

	// queue entry: classified request
	typedef struct packed {
		logic [NUM_W-1:0]   number;
		logic [HOSTS_W-1:0] hosts;
		logic               keep;
		logic               last;
	} req_t;

	typedef struct packed {
		logic [NUM_W-1:0]   number;
		logic [HOSTS_W-1:0] hosts;
	} entry_t;

	typedef enum logic [2:0] {
		COLLECT,
		SORT_RDI,
		SORT_LDI,
		SORT_RDJ,
		SORT_CMP,
		SORT_WRI,
		ALLOC_RD,
		ALLOC_EMIT
	} back_state_t;

endpackage

[design/vlsm_subnet_allocator.sv]
// VLSM subnet allocator for one 256-address space. Requests are taken one
// beat per cycle while the queue is not full into a four-entry queue and
// stored in a single-port-write memory; the beat with last_request closes
// the set. Stored requests are then exchange-sorted in that memory while no
// new request is drained from the queue; after that result beats leave one
// at a time, each waiting for the memory's registered read and held while
// out_stall is high. start_offset may be written only while the block is
// idle; cfg_ready is always high.
module vlsm_subnet_allocator #(
	parameter int MAX_SUBNETS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [vsa_pkg::ADDR_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  vsa_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output vsa_pkg::out_t               out_data
);

	logic                       push, pop, q_full, q_empty;
	vsa_pkg::req_t              push_data, q_head;
	logic [vsa_pkg::ADDR_W-1:0] start_q;

	assign cfg_ready = 1'b1;

	// start offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	vsa_front #(.MAX_SUBNETS(MAX_SUBNETS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	vsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	vsa_back #(.MAX_SUBNETS(MAX_SUBNETS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_offset(start_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

[design/vsa_ram.sv]
module vsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/vsa_front.sv]
// Accepts request beats, numbers them and marks drops once the store is full.
module vsa_front #(
	parameter int MAX_SUBNETS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  vsa_pkg::in_t   in_data,
	output logic           push,
	output vsa_pkg::req_t  push_data,
	input  logic           q_full
);

	localparam int CW = $clog2(MAX_SUBNETS + 1);

	logic [CW-1:0] count_q;
	logic          keep;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign keep     = count_q < CW'(MAX_SUBNETS);

	// classification of the incoming beat
	always_comb begin
		push_data.number = vsa_pkg::NUM_W'(count_q + CW'(1));
		push_data.hosts  = in_data.required_hosts;
		push_data.keep   = keep;
		push_data.last   = in_data.last_request;
	end

	// arrival counter, restarts after the closing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (in_data.last_request) begin
				count_q <= '0;
			end else if (keep) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

[design/vsa_queue.sv]
// Small request queue between front and back.
module vsa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vsa_pkg::req_t push_data,
	output logic          full,
	input  logic          pop,
	output vsa_pkg::req_t head,
	output logic          empty
);

	localparam int PW = $clog2(vsa_pkg::Q_DEPTH);

	vsa_pkg::req_t                 slot_q [vsa_pkg::Q_DEPTH];
	logic [PW-1:0]                 wr_q;
	logic [PW-1:0]                 rd_q;
	logic [vsa_pkg::Q_CNT_W-1:0]   cnt_q;

	assign full  = cnt_q == vsa_pkg::Q_CNT_W'(vsa_pkg::Q_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop)  rd_q <= rd_q + PW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + vsa_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - vsa_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/vsa_back.sv]
// Stores a set, exchange-sorts it in memory, then places blocks one per beat.
module vsa_back #(
	parameter int MAX_SUBNETS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vsa_pkg::ADDR_W-1:0]  start_offset,
	input  logic                        q_empty,
	input  vsa_pkg::req_t               q_head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output vsa_pkg::out_t               out_data
);

	localparam int AW = MAX_SUBNETS > 1 ? $clog2(MAX_SUBNETS) : 1;
	localparam int CW = $clog2(MAX_SUBNETS + 1);

	vsa_pkg::back_state_t state_q, state_d;

	logic [CW-1:0]              cnt_q, cnt_d;
	logic [CW-1:0]              i_q, i_d, j_q, j_d, k_q, k_d;
	vsa_pkg::entry_t            cur_q, cur_d;
	logic [vsa_pkg::SIZE_W-1:0] fp_q, fp_d;

	logic                       we;
	logic [AW-1:0]              waddr, raddr;
	vsa_pkg::entry_t            wdata, rdata;

	logic                       out_valid_q;
	vsa_pkg::out_t              out_q, res;
	logic                       emit;

	// block sizing for the entry at the read port
	logic [vsa_pkg::HOSTS_W:0]  needed;
	logic [3:0]                 hbits;
	logic [vsa_pkg::SIZE_W-1:0] size;
	logic [vsa_pkg::SIZE_W:0]   end_addr;
	logic [vsa_pkg::ADDR_W-1:0] net, bc;

	vsa_ram #(.WIDTH(vsa_pkg::ENTRY_W), .DEPTH(MAX_SUBNETS)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		needed = {1'b0, rdata.hosts} + (vsa_pkg::HOSTS_W + 1)'(2);
		hbits  = 4'd9;
		for (int b = vsa_pkg::MAX_BITS; b >= 1; b--) begin
			if (((vsa_pkg::HOSTS_W + 1)'(1) << b) >= needed) hbits = 4'(b);
		end
		size     = vsa_pkg::SIZE_W'(1) << hbits[3:0];
		end_addr = {1'b0, fp_q} + {1'b0, size};
		net      = fp_q[vsa_pkg::ADDR_W-1:0];
		bc       = net + size[vsa_pkg::ADDR_W-1:0] - vsa_pkg::ADDR_W'(1);

		res                 = '0;
		res.subnet_number   = rdata.number;
		res.hosts_echo      = rdata.hosts;
		res.last_result     = (k_q + CW'(1)) == cnt_q;
		if (hbits > 4'(vsa_pkg::MAX_BITS)) begin
			res.status = vsa_pkg::ST_TOO_BIG;
		end else if (end_addr > (vsa_pkg::SIZE_W + 1)'(vsa_pkg::SPACE)) begin
			res.status = vsa_pkg::ST_NO_SPACE;
		end else begin
			res.status          = vsa_pkg::ST_OK;
			res.network_addr    = net;
			res.first_host_addr = net + vsa_pkg::ADDR_W'(1);
			res.last_host_addr  = bc - vsa_pkg::ADDR_W'(1);
			res.broadcast_addr  = bc;
			res.prefix_len      = vsa_pkg::PFX_W'(6'd32 - {2'b0, hbits});
			res.block_size      = size;
		end
	end

	// sequencer: collect, sort, allocate
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		cur_d   = cur_q;
		fp_d    = fp_q;
		pop     = 1'b0;
		we      = 1'b0;
		waddr   = cnt_q[AW-1:0];
		wdata   = '{number: q_head.number, hosts: q_head.hosts};
		raddr   = i_q[AW-1:0];
		emit    = 1'b0;
		case (state_q)
			vsa_pkg::COLLECT: begin
				if (!q_empty) begin
					pop = 1'b1;
					we  = q_head.keep;
					if (q_head.keep) cnt_d = cnt_q + CW'(1);
					if (q_head.last) begin
						i_d  = '0;
						k_d  = '0;
						fp_d = {1'b0, start_offset};
						if (cnt_d >= CW'(2)) begin
							state_d = vsa_pkg::SORT_RDI;
						end else if (cnt_d == CW'(1)) begin
							state_d = vsa_pkg::ALLOC_RD;
						end else begin
							cnt_d = '0;
						end
					end
				end
			end
			vsa_pkg::SORT_RDI: begin
				raddr   = i_q[AW-1:0];
				state_d = vsa_pkg::SORT_LDI;
			end
			vsa_pkg::SORT_LDI: begin
				cur_d   = rdata;
				j_d     = i_q + CW'(1);
				state_d = vsa_pkg::SORT_RDJ;
			end
			vsa_pkg::SORT_RDJ: begin
				raddr   = j_q[AW-1:0];
				state_d = vsa_pkg::SORT_CMP;
			end
			vsa_pkg::SORT_CMP: begin
				raddr = j_q[AW-1:0];
				if (cur_q.hosts < rdata.hosts) begin
					we    = 1'b1;
					waddr = j_q[AW-1:0];
					wdata = cur_q;
					cur_d = rdata;
				end
				if (j_q + CW'(1) == cnt_q) begin
					state_d = vsa_pkg::SORT_WRI;
				end else begin
					j_d     = j_q + CW'(1);
					state_d = vsa_pkg::SORT_RDJ;
				end
			end
			vsa_pkg::SORT_WRI: begin
				we    = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = cur_q;
				i_d   = i_q + CW'(1);
				if (i_q + CW'(2) >= cnt_q) begin
					state_d = vsa_pkg::ALLOC_RD;
				end else begin
					state_d = vsa_pkg::SORT_RDI;
				end
			end
			vsa_pkg::ALLOC_RD: begin
				raddr   = k_q[AW-1:0];
				state_d = vsa_pkg::ALLOC_EMIT;
			end
			vsa_pkg::ALLOC_EMIT: begin
				raddr = k_q[AW-1:0];
				if (!out_valid_q || !out_stall) begin
					emit = 1'b1;
					if (res.status == vsa_pkg::ST_OK) fp_d = fp_q + size;
					if (res.last_result) begin
						cnt_d   = '0;
						state_d = vsa_pkg::COLLECT;
					end else begin
						k_d     = k_q + CW'(1);
						state_d = vsa_pkg::ALLOC_RD;
					end
				end
			end
			default: state_d = vsa_pkg::COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vsa_pkg::COLLECT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q   <= i_d;
		j_q   <= j_d;
		k_q   <= k_d;
		cur_q <= cur_d;
		fp_q  <= fp_d;
		if (emit) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a kept request always finds room in the store
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_head.keep) |-> (cnt_q < CW'(MAX_SUBNETS)))
		else $error("store overflow");

	// sorting only runs on sets of two or more
	a_sort_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vsa_pkg::SORT_RDI) |-> (cnt_q >= CW'(2)))
		else $error("sort on short set");

	// the final result of a set sends the sequencer back to collecting
	a_set_close: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res.last_result) |=> (state_q == vsa_pkg::COLLECT && cnt_q == '0))
		else $error("set not closed");

endmodule
